### rtl/sc1kd_pkg.sv
`default_nettype none
package sc1kd_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;

    localparam int EVENT_W = 18;
    localparam int COUNT_W = 32;
    localparam int CODE_W  = 7;
    localparam int CHAR_W  = 7;
    localparam int QCNT_W  = 6;
    localparam int OUT_DATA_W = 120;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] CODE_LCTRL  = 7'h1D;
    localparam logic [6:0] CODE_LALT   = 7'h38;
    localparam logic [6:0] CODE_CAPS   = 7'h3A;

    typedef enum logic [2:0] {
        OUT_QUEUED    = 3'd0,
        OUT_PREFIX    = 3'd1,
        OUT_DROPPED   = 3'd2,
        OUT_DELIVERED = 3'd3,
        OUT_EMPTY     = 3'd4
    } outcome_t;

    // Queued event layout, from the lowest bit up: pressed, make code, character,
    // shift, control, alt.
    typedef struct packed {
        logic              alt;
        logic              control;
        logic              shift;
        logic [CHAR_W-1:0] character;
        logic [CODE_W-1:0] scancode;
        logic              pressed;
    } event_t;

    function automatic logic [CHAR_W-1:0] lower_char(input logic [CODE_W-1:0] make);
        logic [CHAR_W-1:0] c;
        begin
            unique case (make)
                7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
                7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
                7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
                7'h0E: c = 7'h08;  7'h0F: c = 7'h09;  7'h10: c = 7'h71;  7'h11: c = 7'h77;
                7'h12: c = 7'h65;  7'h13: c = 7'h72;  7'h14: c = 7'h74;  7'h15: c = 7'h79;
                7'h16: c = 7'h75;  7'h17: c = 7'h69;  7'h18: c = 7'h6F;  7'h19: c = 7'h70;
                7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;  7'h1C: c = 7'h0A;  7'h1E: c = 7'h61;
                7'h1F: c = 7'h73;  7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;
                7'h23: c = 7'h68;  7'h24: c = 7'h6A;  7'h25: c = 7'h6B;  7'h26: c = 7'h6C;
                7'h27: c = 7'h3B;  7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2B: c = 7'h5C;
                7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
                7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
                7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] upper_char(input logic [CODE_W-1:0] make);
        logic [CHAR_W-1:0] c;
        begin
            unique case (make)
                7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
                7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
                7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
                7'h0E: c = 7'h08;  7'h0F: c = 7'h09;  7'h10: c = 7'h51;  7'h11: c = 7'h57;
                7'h12: c = 7'h45;  7'h13: c = 7'h52;  7'h14: c = 7'h54;  7'h15: c = 7'h59;
                7'h16: c = 7'h55;  7'h17: c = 7'h49;  7'h18: c = 7'h4F;  7'h19: c = 7'h50;
                7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;  7'h1C: c = 7'h0A;  7'h1E: c = 7'h41;
                7'h1F: c = 7'h53;  7'h20: c = 7'h44;  7'h21: c = 7'h46;  7'h22: c = 7'h47;
                7'h23: c = 7'h48;  7'h24: c = 7'h4A;  7'h25: c = 7'h4B;  7'h26: c = 7'h4C;
                7'h27: c = 7'h3A;  7'h28: c = 7'h22;  7'h29: c = 7'h7E;  7'h2B: c = 7'h7C;
                7'h2C: c = 7'h5A;  7'h2D: c = 7'h58;  7'h2E: c = 7'h43;  7'h2F: c = 7'h56;
                7'h30: c = 7'h42;  7'h31: c = 7'h4E;  7'h32: c = 7'h4D;  7'h33: c = 7'h3C;
                7'h34: c = 7'h3E;  7'h35: c = 7'h3F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

    // Caps lock swaps the case of letters only; bit 5 is the case bit in ASCII.
    function automatic logic [CHAR_W-1:0] char_lookup(input logic [CODE_W-1:0] make,
                                                      input logic sh, input logic caps);
        logic [CHAR_W-1:0] c;
        logic              letter;
        begin
            c = sh ? upper_char(make) : lower_char(make);
            letter = (c >= 7'h61 && c <= 7'h7A) || (c >= 7'h41 && c <= 7'h5A);
            if (caps && letter) begin
                c[5] = ~c[5];
            end
            return c;
        end
    endfunction

endpackage
`default_nettype wire

### rtl/sc1kd_ram.sv
`default_nettype none
module sc1kd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/scancode_set1_key_event_decoder.sv
// A result passes the first stage (ring read) and then the output register.
// Throughput: one item per cycle when the output is free; at most one ring access per item.
// One further item is accepted while a finished result waits to be taken.
// Reset clears indices, fill count, modifier and prefix flags, counters and valid flags.
// The ring memory itself is not cleared: only entries written earlier are ever read.
`default_nettype none
module scancode_set1_key_event_decoder
    import sc1kd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] scan_byte
    input  wire logic                  s_tuser,   // [0] req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] ev_pressed, [7:1] ev_scancode, [14:8] ev_character, [15] ev_shift,
    // [16] ev_control, [17] ev_alt, [23:18] queued_count, [55:24] dropped_total,
    // [87:56] event_total, [119:88] prefix_total
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [2:0]                 m_tuser    // [2:0] outcome
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH - 1);

    logic accept;
    logic s1_adv;

    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               shift_reg, shift_next;
    logic               ctrl_reg, ctrl_next;
    logic               alt_reg, alt_next;
    logic               caps_reg, caps_next;
    logic               prefix_reg, prefix_next;
    logic [COUNT_W-1:0] dropped_reg, dropped_next;
    logic [COUNT_W-1:0] events_reg, events_next;
    logic [COUNT_W-1:0] prefixes_reg, prefixes_next;

    logic               s1_valid_reg;
    outcome_t           s1_outcome_reg, s1_outcome_next;
    logic               s1_deliver_reg, s1_deliver_next;
    logic [QCNT_W-1:0]  s1_queued_reg, s1_queued_next;
    logic [COUNT_W-1:0] s1_dropped_reg, s1_events_reg, s1_prefixes_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [2:0]            out_user_reg;

    logic                ram_we, ram_re;
    event_t              ram_wdata;
    logic [EVENT_W-1:0]  ram_rdata;
    logic [EVENT_W-1:0]  delivered;

    logic [6:0]          make;
    logic                pressed;
    logic                ext;
    logic [CNT_W+QCNT_W-1:0] fill_wide;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    assign make    = s_tdata[6:0];
    assign pressed = !s_tdata[7];
    assign ext     = prefix_reg;

    always_comb begin
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        fill_next       = fill_reg;
        shift_next      = shift_reg;
        ctrl_next       = ctrl_reg;
        alt_next        = alt_reg;
        caps_next       = caps_reg;
        prefix_next     = prefix_reg;
        dropped_next    = dropped_reg;
        events_next     = events_reg;
        prefixes_next   = prefixes_reg;
        s1_outcome_next = OUT_EMPTY;
        s1_deliver_next = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_wdata       = '0;

        if (accept) begin
            if (s_tuser) begin
                if (fill_reg != '0) begin
                    ram_re          = 1'b1;
                    rd_idx_next     = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
                    fill_next       = fill_reg - 1'b1;
                    s1_outcome_next = OUT_DELIVERED;
                    s1_deliver_next = 1'b1;
                end
            end else if (s_tdata == PREFIX_BYTE) begin
                prefix_next     = 1'b1;
                ctrl_next       = 1'b0;
                prefixes_next   = prefixes_reg + 1'b1;
                s1_outcome_next = OUT_PREFIX;
            end else begin
                prefix_next = 1'b0;
                // Extended control and alt codes belong to the right-hand keys and
                // release the left-hand modifier.
                priority if (make == CODE_LSHIFT || make == CODE_RSHIFT) begin
                    shift_next = pressed;
                end else if (make == CODE_LCTRL) begin
                    ctrl_next = !ext && pressed;
                end else if (make == CODE_LALT) begin
                    alt_next = !ext && pressed;
                end else if (make == CODE_CAPS && pressed) begin
                    caps_next = !caps_reg;
                end

                ram_wdata.pressed   = pressed;
                ram_wdata.scancode  = make;
                ram_wdata.character = pressed ? char_lookup(make, shift_next, caps_next) : '0;
                ram_wdata.shift     = shift_next;
                ram_wdata.control   = ctrl_next;
                ram_wdata.alt       = alt_next;

                if (fill_reg == FULL_CNT) begin
                    dropped_next    = dropped_reg + 1'b1;
                    s1_outcome_next = OUT_DROPPED;
                end else begin
                    ram_we          = 1'b1;
                    wr_idx_next     = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
                    fill_next       = fill_reg + 1'b1;
                    events_next     = events_reg + 1'b1;
                    s1_outcome_next = OUT_QUEUED;
                end
            end
        end
    end

    assign fill_wide      = {{QCNT_W{1'b0}}, fill_next};
    assign s1_queued_next = fill_wide[QCNT_W-1:0];

    // A read and a write never address the same entry in one cycle: a read only
    // touches entries that hold an item, the write goes to the free slot.
    sc1kd_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // The read data stays on the memory output until the next read, so a
    // stalled first stage still sees its entry.
    assign delivered     = s1_deliver_reg ? ram_rdata : '0;
    assign out_data_next = {s1_prefixes_reg, s1_events_reg, s1_dropped_reg,
                            s1_queued_reg, delivered};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            fill_reg      <= '0;
            shift_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
            alt_reg       <= 1'b0;
            caps_reg      <= 1'b0;
            prefix_reg    <= 1'b0;
            dropped_reg   <= '0;
            events_reg    <= '0;
            prefixes_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            fill_reg     <= fill_next;
            shift_reg    <= shift_next;
            ctrl_reg     <= ctrl_next;
            alt_reg      <= alt_next;
            caps_reg     <= caps_next;
            prefix_reg   <= prefix_next;
            dropped_reg  <= dropped_next;
            events_reg   <= events_next;
            prefixes_reg <= prefixes_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_outcome_reg  <= s1_outcome_next;
            s1_deliver_reg  <= s1_deliver_next;
            s1_queued_reg   <= s1_queued_next;
            s1_dropped_reg  <= dropped_next;
            s1_events_reg   <= events_next;
            s1_prefixes_reg <= prefixes_next;
        end
        if (s1_adv) begin
            out_data_reg <= out_data_next;
            out_user_reg <= s1_outcome_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

### rtl/sc1kd_checker.sv
`default_nettype none
module sc1kd_checker
    import sc1kd_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [7:0]            s_tdata,
    input wire logic                  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [2:0]            m_tuser
);

    logic s_seen;

    assign s_seen = s_tvalid && s_tready && (s_tuser || !s_tuser) && (s_tdata == s_tdata);

    // A result held back by the sink keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only a delivery carries event fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != OUT_DELIVERED |-> m_tdata[17:0] == 18'd0)
        else $error("event fields set on a non-delivery");

    // A released key never carries a character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OUT_DELIVERED && !m_tdata[0] |-> m_tdata[14:8] == 7'd0)
        else $error("character on a released key");

    // An empty report means the ring count is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OUT_EMPTY |-> m_tdata[23:18] == 6'd0)
        else $error("empty outcome with items counted");

    // No result without an earlier accepted item, starting from reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_seen, 2) || $past(m_tvalid))
        else $error("result without an accepted item");

endmodule

bind scancode_set1_key_event_decoder sc1kd_checker u_sc1kd_checker (.*);
`default_nettype wire

### bench/keystroke_checker.sv
`default_nettype none
module keystroke_checker
    import sc1kd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [7:0]            s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [2:0]            m_tuser,
    output int                         mismatches,
    output int                         awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS = DEFAULT_QUEUE_DEPTH - 1;

    // Keys whose characters are control codes rather than printable glyphs.
    localparam logic [6:0] KEY_BACKSPACE = 7'h0E;
    localparam logic [6:0] KEY_TAB       = 7'h0F;
    localparam logic [6:0] KEY_ENTER     = 7'h1C;
    localparam logic [6:0] ASCII_BS      = 7'h08;
    localparam logic [6:0] ASCII_HT      = 7'h09;
    localparam logic [6:0] ASCII_LF      = 7'h0A;

    typedef struct {
        outcome_t    outcome;
        event_t      ev;
        logic [5:0]  fill;
        logic [31:0] drops;
        logic [31:0] queued;
        logic [31:0] prefixes;
    } key_result_t;

    logic [6:0]  plain_glyph [128];
    logic [6:0]  shifted_glyph [128];

    event_t      held_events [$];
    key_result_t expected_results [$];
    logic        shift_down = 1'b0;
    logic        ctrl_down = 1'b0;
    logic        alt_down = 1'b0;
    logic        caps_engaged = 1'b0;
    logic        extended = 1'b0;
    logic [31:0] drop_count = '0;
    logic [31:0] event_count = '0;
    logic [31:0] prefix_seen = '0;
    int          fail_total = 0;
    int          backlog = 0;
    int          result_no = 0;

    assign mismatches = fail_total;
    assign awaiting = backlog;

    // Each row is indexed by make code; X and x mark keys without a character.
    initial begin
        string plain_row;
        string shifted_row;
        byte   ch;
        plain_row   = "XX1234567890-=XXqwertyuiop[]XXasdfghjkl;'`X\\zxcvbnm,./X*X ";
        shifted_row = "xx!@#$%^&*()_+xxQWERTYUIOP{}xxASDFGHJKL:\"~x|ZXCVBNM<>?x*x ";
        for (int i = 0; i < 128; i++) begin
            plain_glyph[i] = '0;
            shifted_glyph[i] = '0;
        end
        for (int i = 0; i < plain_row.len(); i++) begin
            ch = plain_row[i];
            if (ch != "X") plain_glyph[i] = ch[6:0];
            ch = shifted_row[i];
            if (ch != "x") shifted_glyph[i] = ch[6:0];
        end
        plain_glyph[KEY_BACKSPACE] = ASCII_BS;
        plain_glyph[KEY_TAB] = ASCII_HT;
        plain_glyph[KEY_ENTER] = ASCII_LF;
        shifted_glyph[KEY_BACKSPACE] = ASCII_BS;
        shifted_glyph[KEY_TAB] = ASCII_HT;
        shifted_glyph[KEY_ENTER] = ASCII_LF;
    end

    function automatic logic [6:0] key_char(input logic [6:0] make);
        logic [6:0] c;
        c = shift_down ? shifted_glyph[make] : plain_glyph[make];
        if (caps_engaged) begin
            if (c >= "a" && c <= "z") c = c - 7'd32;
            else if (c >= "A" && c <= "Z") c = c + 7'd32;
        end
        return c;
    endfunction

    function automatic key_result_t predict_result(input logic is_read, input logic [7:0] b);
        key_result_t r;
        event_t      e;
        logic [6:0]  make;
        logic        press;
        logic        ext;
        r.ev = '0;
        if (is_read) begin
            if (held_events.size() == 0) begin
                r.outcome = OUT_EMPTY;
            end else begin
                r.ev = held_events.pop_front();
                r.outcome = OUT_DELIVERED;
            end
        end else if (b == PREFIX_BYTE) begin
            extended = 1'b1;
            ctrl_down = 1'b0;
            prefix_seen = prefix_seen + 1;
            r.outcome = OUT_PREFIX;
        end else begin
            ext = extended;
            extended = 1'b0;
            make = b[6:0];
            press = ~b[7];
            // Extended control and alt are the right-hand keys, which release the left one.
            if (make == CODE_LSHIFT || make == CODE_RSHIFT) shift_down = press;
            else if (make == CODE_LCTRL) ctrl_down = press & ~ext;
            else if (make == CODE_LALT) alt_down = press & ~ext;
            else if (make == CODE_CAPS && press) caps_engaged = ~caps_engaged;
            e.pressed = press;
            e.scancode = make;
            e.character = press ? key_char(make) : '0;
            e.shift = shift_down;
            e.control = ctrl_down;
            e.alt = alt_down;
            if (held_events.size() == RING_SLOTS) begin
                drop_count = drop_count + 1;
                r.outcome = OUT_DROPPED;
            end else begin
                held_events.push_back(e);
                event_count = event_count + 1;
                r.outcome = OUT_QUEUED;
            end
        end
        r.fill = 6'(held_events.size());
        r.drops = drop_count;
        r.queued = event_count;
        r.prefixes = prefix_seen;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_total++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                      result_no, field, got, want));
    endtask

    always @(posedge aclk) begin
        key_result_t want;
        event_t      got_ev;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_result(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_no));
                end else begin
                    want = expected_results.pop_front();
                    got_ev = m_tdata[17:0];
                    check_field("outcome", m_tuser, want.outcome);
                    check_field("ev_pressed", got_ev.pressed, want.ev.pressed);
                    check_field("ev_scancode", got_ev.scancode, want.ev.scancode);
                    check_field("ev_character", got_ev.character, want.ev.character);
                    check_field("ev_shift", got_ev.shift, want.ev.shift);
                    check_field("ev_control", got_ev.control, want.ev.control);
                    check_field("ev_alt", got_ev.alt, want.ev.alt);
                    check_field("queued_count", m_tdata[23:18], want.fill);
                    check_field("dropped_total", m_tdata[55:24], want.drops);
                    check_field("event_total", m_tdata[87:56], want.queued);
                    check_field("prefix_total", m_tdata[119:88], want.prefixes);
                end
                result_no++;
            end
            backlog = expected_results.size();
        end
    end

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sc1kd_pkg::*;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;
    localparam int   QUIET_LIMIT = 500;
    localparam int   PHASES = 20;
    localparam int   PHASE_ITEMS = 100;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = REQ_SCAN;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    int                    mismatches;
    int                    awaiting;
    bit                    sender_gaps = 1'b0;
    bit                    receiver_stalls = 1'b0;
    int                    quiet_cycles = 0;

    scancode_set1_key_event_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    keystroke_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic kind, input logic [7:0] value);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tuser <= kind;
        s_tdata <= value;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Mostly plausible key traffic, with modifiers and prefixes weighted up.
    function automatic logic [7:0] pick_scan_byte();
        logic [6:0] make;
        logic       release_bit;
        release_bit = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 9))
            0: return PREFIX_BYTE;
            1, 2: begin
                case ($urandom_range(0, 4))
                    0: make = CODE_LSHIFT;
                    1: make = CODE_RSHIFT;
                    2: make = CODE_LCTRL;
                    3: make = CODE_LALT;
                    default: make = CODE_CAPS;
                endcase
                release_bit = 1'($urandom_range(0, 1));
            end
            3, 4, 5, 6: make = 7'($urandom_range(1, 8'h3A));
            default: return 8'($urandom_range(0, 255));
        endcase
        return {release_bit, make};
    endfunction

    initial begin
        int read_pct;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Prefix handling, modifier tracking, caps lock case swapping, and reads of an empty and a filled ring.
        send_item(REQ_READ, 8'hFF);
        send_item(REQ_SCAN, PREFIX_BYTE);
        send_item(REQ_SCAN, PREFIX_BYTE);
        send_item(REQ_SCAN, 8'h1D);
        send_item(REQ_SCAN, 8'h1D);
        send_item(REQ_SCAN, 8'h38);
        send_item(REQ_SCAN, PREFIX_BYTE);
        send_item(REQ_SCAN, 8'h38);
        send_item(REQ_SCAN, 8'h2A);
        send_item(REQ_SCAN, 8'h1E);
        send_item(REQ_SCAN, 8'h3A);
        send_item(REQ_SCAN, 8'h1E);
        send_item(REQ_SCAN, 8'hAA);
        send_item(REQ_SCAN, 8'h1E);
        send_item(REQ_SCAN, 8'hBA);
        send_item(REQ_SCAN, 8'h02);
        send_item(REQ_SCAN, PREFIX_BYTE);
        send_item(REQ_SCAN, 8'h36);
        send_item(REQ_SCAN, 8'h00);
        send_item(REQ_SCAN, 8'hFF);
        send_item(REQ_SCAN, 8'h39);
        send_item(REQ_SCAN, 8'h0E);
        send_item(REQ_READ, 8'h00);
        send_item(REQ_READ, 8'h5A);
        send_item(REQ_READ, 8'hA5);

        // The first phase never reads, so the ring fills and events are dropped;
        // later phases mix filling and draining. The closing phases run without idling.
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: read_pct = 0;
                1: read_pct = 10;
                2: read_pct = 50;
                default: read_pct = 90;
            endcase
            if (ph == 0) read_pct = 0;
            sender_gaps = (ph < PHASES - 3) && ($urandom_range(0, 2) != 0);
            receiver_stalls = (ph < PHASES - 3) && ($urandom_range(0, 2) != 0);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(1, 100) <= read_pct)
                    send_item(REQ_READ, 8'($urandom_range(0, 255)));
                else
                    send_item(REQ_SCAN, pick_scan_byte());
            end
        end
        s_tvalid <= 1'b0;

        while (awaiting != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0 && awaiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
`default_nettype wire

### files.f
rtl/sc1kd_pkg.sv
rtl/sc1kd_ram.sv
rtl/scancode_set1_key_event_decoder.sv
rtl/sc1kd_checker.sv
bench/keystroke_checker.sv
bench/tb.sv
